FILE: hw/rtl/kmhq_pkg.sv
`default_nettype none

package kmhq_pkg;

  localparam int unsigned KeyWidth    = 32;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned ArityWidth  = 4;
  localparam int unsigned StatusWidth = 2;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  localparam logic [StatusWidth-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd2;

  localparam logic [ArityWidth-1:0] ARITY_RESET = 4'd2;
  localparam logic [ArityWidth-1:0] ARITY_MIN   = 4'd2;

  typedef struct packed {
    logic                       func;
    logic signed [KeyWidth-1:0] value;
  } kmhq_req_t;

  typedef struct packed {
    logic signed [KeyWidth-1:0] out_value;
    logic [StatusWidth-1:0]     status;
    logic [CountWidth-1:0]      count;
  } kmhq_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kmhq_ram.sv
`default_nettype none

module kmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kary_min_heap_queue_unit.sv
`default_nettype none

// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    kmhq_req_t (func, value)
// rsp      out        rsp_valid / rsp_ready    kmhq_rsp_t (out_value, status, count)
// cfg      in         cfg_wr_en                cfg_wr_data (arity)
//
// One request at a time; req_ready is high only while the sequencer is idle.
// An insert sifts the new key up, finding each parent with the bit-serial parent
// divider; an extract sifts the last key down from the root over up to k children.
// Rejected requests go straight to S_FINISH. Synchronous reset empties the heap.
// A result waits in the output register while the next request is accepted.

module kary_min_heap_queue_unit #(
  parameter int unsigned CAPACITY  = 128,
  parameter int unsigned MAX_ARITY = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 req_valid,
  output logic                                      req_ready,
  input  wire kmhq_pkg::kmhq_req_t                  req,
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_ready,
  output kmhq_pkg::kmhq_rsp_t                       rsp,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [kmhq_pkg::ArityWidth-1:0]      cfg_wr_data
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = $clog2(MAX_ARITY + 1);
  localparam int unsigned XW = $clog2(MAX_ARITY * CAPACITY + MAX_ARITY + 1);
  localparam int unsigned DW = $clog2(PW + 1);
  localparam int unsigned KEYW = kmhq_pkg::KeyWidth;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_UP_CHECK = 11'b000_0000_0010,
    S_UP_DIV   = 11'b000_0000_0100,
    S_UP_RD    = 11'b000_0000_1000,
    S_UP_CMP   = 11'b000_0001_0000,
    S_DN_LAST  = 11'b000_0010_0000,
    S_DN_LOAD  = 11'b000_0100_0000,
    S_DN_BASE  = 11'b000_1000_0000,
    S_DN_CMP   = 11'b001_0000_0000,
    S_DN_DEC   = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t                               state;
  logic [CW-1:0]                        count;
  logic [kmhq_pkg::ArityWidth-1:0]      arity;
  logic signed [KEYW-1:0]               key;
  logic [PW-1:0]                        pos;
  logic [PW-1:0]                        dq;
  logic [KW-1:0]                        rem;
  logic [DW-1:0]                        dcnt;
  logic [XW-1:0]                        child;
  logic [KW-1:0]                        ci;
  logic                                 found;
  logic signed [KEYW-1:0]               best_val;
  logic [PW-1:0]                        best_idx;
  logic signed [KEYW-1:0]               res_val;
  logic [kmhq_pkg::StatusWidth-1:0]     res_status;

  logic [KW-1:0]                        k_eff;
  logic [KW:0]                          rem_sh;
  logic                                 q_bit;
  logic [KW-1:0]                        rem_next;
  logic [PW-1:0]                        dq_next;
  logic [XW-1:0]                        base;
  logic signed [KEYW-1:0]               rd_key;
  logic                                 take;
  logic [KW-1:0]                        ci_next;
  logic [XW-1:0]                        child_next;
  logic                                 scan_last;

  logic                                 mem_we;
  logic [PW-1:0]                        mem_waddr;
  logic [KEYW-1:0]                      mem_wdata;
  logic [PW-1:0]                        mem_raddr;
  logic [KEYW-1:0]                      mem_rdata;

  kmhq_ram #(
    .WIDTH(KEYW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    if (arity < kmhq_pkg::ARITY_MIN) begin
      k_eff = KW'(kmhq_pkg::ARITY_MIN);
    end else if (32'(arity) > MAX_ARITY) begin
      k_eff = KW'(MAX_ARITY);
    end else begin
      k_eff = KW'(arity);
    end
  end

  assign rem_sh   = {rem, dq[PW-1]};
  assign q_bit    = (rem_sh >= {1'b0, k_eff});
  assign rem_next = q_bit ? KW'(rem_sh - {1'b0, k_eff}) : rem_sh[KW-1:0];
  assign dq_next  = PW'({dq, q_bit});

  assign base       = XW'(k_eff) * XW'(pos) + XW'(1);
  assign rd_key     = $signed(mem_rdata);
  assign take       = !found || (rd_key < best_val);
  assign ci_next    = ci + KW'(1);
  assign child_next = child + XW'(1);
  assign scan_last  = (ci_next >= k_eff) || (child_next >= XW'(count));

  assign req_ready = (state == S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = key;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        mem_raddr = '0;
      end
      S_UP_CHECK: begin
        mem_we = (pos == '0);
      end
      S_UP_RD: begin
        mem_raddr = dq;
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (key < rd_key) begin
          mem_wdata = mem_rdata;
        end
      end
      S_DN_LAST: begin
        mem_raddr = PW'(count);
      end
      S_DN_BASE: begin
        mem_raddr = PW'(base);
        mem_we    = (base >= XW'(count));
      end
      S_DN_CMP: begin
        mem_raddr = PW'(child_next);
      end
      S_DN_DEC: begin
        mem_we = 1'b1;
        if (best_val < key) begin
          mem_wdata = best_val;
        end
      end
      S_UP_DIV, S_DN_LOAD, S_FINISH: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      arity     <= kmhq_pkg::ARITY_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        arity <= cfg_wr_data;
      end
      if (rsp_valid && rsp_ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            res_val <= '0;
            if (req.func == kmhq_pkg::FUNC_INSERT) begin
              if (count >= CW'(CAPACITY)) begin
                res_status <= kmhq_pkg::STATUS_FULL;
                state      <= S_FINISH;
              end else begin
                res_status <= kmhq_pkg::STATUS_DONE;
                key        <= req.value;
                pos        <= PW'(count);
                count      <= count + CW'(1);
                state      <= S_UP_CHECK;
              end
            end else begin
              if (count == '0) begin
                res_status <= kmhq_pkg::STATUS_EMPTY;
                state      <= S_FINISH;
              end else begin
                res_status <= kmhq_pkg::STATUS_DONE;
                count      <= count - CW'(1);
                state      <= S_DN_LAST;
              end
            end
          end
        end
        S_UP_CHECK: begin
          if (pos == '0) begin
            state <= S_FINISH;
          end else begin
            dq    <= pos - PW'(1);
            rem   <= '0;
            dcnt  <= DW'(PW);
            state <= S_UP_DIV;
          end
        end
        S_UP_DIV: begin
          dq   <= dq_next;
          rem  <= rem_next;
          dcnt <= dcnt - DW'(1);
          if (dcnt == DW'(1)) begin
            state <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (key < rd_key) begin
            pos   <= dq;
            state <= S_UP_CHECK;
          end else begin
            state <= S_FINISH;
          end
        end
        S_DN_LAST: begin
          res_val <= rd_key;
          state   <= S_DN_LOAD;
        end
        S_DN_LOAD: begin
          key   <= rd_key;
          pos   <= '0;
          state <= S_DN_BASE;
        end
        S_DN_BASE: begin
          if (base >= XW'(count)) begin
            state <= S_FINISH;
          end else begin
            child <= base;
            ci    <= '0;
            found <= 1'b0;
            state <= S_DN_CMP;
          end
        end
        S_DN_CMP: begin
          if (take) begin
            best_val <= rd_key;
            best_idx <= PW'(child);
            found    <= 1'b1;
          end
          child <= child_next;
          ci    <= ci_next;
          if (scan_last) begin
            state <= S_DN_DEC;
          end
        end
        S_DN_DEC: begin
          if (best_val < key) begin
            pos   <= best_idx;
            state <= S_DN_BASE;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.out_value <= res_val;
            rsp.status    <= res_status;
            rsp.count     <= kmhq_pkg::CountWidth'(count);
            rsp_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
